@@ rtl/core/osc_sel_pkg.sv @@
// Package: shared types, band tables and widths for the oscillator setting selector.
`timescale 1ns / 1ps
`default_nettype none
package osc_sel_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned DW    = 34;

  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_SELECT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_START,
    S_CAND,
    S_CWAIT,
    S_EDONE,
    S_NEXT,
    S_KWAIT
  } state_t;

  typedef struct packed {
    logic [31:0] hz;
    logic [11:0] tune;
  } entry_t;

  localparam logic [31:0] BAND_LO [DEPTH] = '{
    32'd30000000, 32'd30000000, 32'd20000000, 32'd15000000,
    32'd12000000, 32'd8000000,  32'd5000000,  32'd4000000,
    32'd5000000,  32'd2000000,  32'd1000000,  32'd200000,
    32'd150000,   32'd100000,   32'd80000,    32'd60000
  };

  localparam logic [31:0] BAND_HI [DEPTH] = '{
    32'd300000000, 32'd250000000, 32'd90000000, 32'd80000000,
    32'd70000000,  32'd55000000,  32'd45000000, 32'd35000000,
    32'd55000000,  32'd40000000,  32'd35000000, 32'd5000000,
    32'd5000000,   32'd2000000,   32'd1500000,  32'd1000000
  };

  // ceil(2^37 / 125): (n >> 3) * KHZ_MUL >> 37 gives n / 1000
  localparam logic [30:0]   KHZ_MUL = 31'd1099511628;
  localparam logic [DW-1:0] KHZ_RND = DW'(999);

endpackage
`default_nettype wire

@@ rtl/core/osc_sel_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module osc_sel_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [osc_sel_pkg::DW-1:0]   num,
  input  wire logic [osc_sel_pkg::DW-1:0]   den,
  output logic                              busy,
  output logic                              done,
  output logic [osc_sel_pkg::DW-1:0]        quo
);
  localparam int unsigned DW = osc_sel_pkg::DW;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    trial    = {rem_r[DW-1:0], q_r[DW-1]};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt  = '0;
      q_nxt    = num;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (go) den_r <= den;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_r)
    else $error("divider restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("done while busy");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("done without run");
endmodule
`default_nettype wire

@@ rtl/core/oscillator_setting_selector_unit.sv @@
// Top level: calibration table and divider selection sequencer.
//
//   channel | ports                               | handshake
//   in      | in_kind, in_entry_index, in_tune... | start && !busy
//   out     | out_status ... out_target_khz       | out_valid, one cycle
//
// Store, clear and rejected items: result in the cycle after acceptance, busy stays low.
// Select: per usable entry one division for the start divider when the target is below
// the entry frequency, then up to seven candidate divisions, and a table walk; kilohertz
// comes from a reciprocal multiply. One shared divider serves all divisions.
// Valid bits clear at reset.
// The result cannot be stalled; it is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module oscillator_setting_selector_unit #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned HALF_MAX = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic [11:0] in_tune_value,
  input  wire logic [31:0] in_entry_hz,
  input  wire logic [31:0] in_target_hz,
  output logic             out_valid,
  output logic             out_status,
  output logic [3:0]       out_chosen_index,
  output logic [11:0]      out_chosen_tune,
  output logic [15:0]      out_half_edges,
  output logic [27:0]      out_achieved_hz,
  output logic [22:0]      out_target_khz
);
  localparam int unsigned DW = osc_sel_pkg::DW;
  localparam logic [DW-1:0] HMAX = DW'(HALF_MAX);
  localparam logic [3:0] LAST = 4'(ENTRIES - 1);

  osc_sel_pkg::entry_t mem [osc_sel_pkg::DEPTH];
  osc_sel_pkg::entry_t rd_r;
  logic [osc_sel_pkg::DEPTH-1:0] valid_r, valid_nxt;
  logic mem_we;

  osc_sel_pkg::state_t state_r, state_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [31:0]   t_r, t_nxt, f_r, f_nxt;
  logic [11:0]   tune_r, tune_nxt;
  logic [DW-1:0] st_r, st_nxt;
  logic [2:0]    k_r, k_nxt;
  logic          single_r, single_nxt;
  logic [DW-1:0] eerr_r, eerr_nxt, ehalf_r, ehalf_nxt, eq_r, eq_nxt;
  logic          gfound_r, gfound_nxt;
  logic [DW-1:0] gerr_r, gerr_nxt, ghalf_r, ghalf_nxt, gq_r, gq_nxt;
  logic [3:0]    gidx_r, gidx_nxt;
  logic [11:0]   gtune_r, gtune_nxt;

  logic          ov_r, ov_nxt, os_r, os_nxt;
  logic [3:0]    oi_r, oi_nxt;
  logic [11:0]   ot_r, ot_nxt;
  logic [15:0]   oh_r, oh_nxt;
  logic [27:0]   oa_r, oa_nxt;
  logic [22:0]   ok_r, ok_nxt;

  logic          div_go, div_busy, div_done;
  logic [DW-1:0] div_num, div_den, div_q;
  logic          accept, in_ok, rd_ok;
  logic [DW-1:0] cand, plus, err;
  logic [DW-1:0] kn;
  logic [59:0]   kprod_r, kprod_nxt;

  osc_sel_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_q)
  );

  assign accept = start && !busy;
  assign in_ok  = (32'(in_entry_index) < 32'(ENTRIES)) &&
                  (in_entry_hz >= osc_sel_pkg::BAND_LO[in_entry_index]) &&
                  (in_entry_hz <= osc_sel_pkg::BAND_HI[in_entry_index]);
  assign mem_we = accept && (in_kind == osc_sel_pkg::KIND_STORE) && in_ok;
  assign rd_ok  = valid_r[idx_r] && (rd_r.hz >= osc_sel_pkg::BAND_LO[idx_r]) &&
                  (rd_r.hz <= osc_sel_pkg::BAND_HI[idx_r]);
  assign plus   = st_r + DW'(k_r);
  assign cand   = plus - DW'(3);
  assign err    = (div_q >= DW'(t_r)) ? div_q - DW'(t_r) : DW'(t_r) - div_q;
  assign kn     = DW'(t_r) + osc_sel_pkg::KHZ_RND;
  assign kprod_nxt = 60'(kn[DW-1:3]) * 60'(osc_sel_pkg::KHZ_MUL);

  always_ff @(posedge clk) begin
    if (mem_we) mem[in_entry_index] <= '{hz: in_entry_hz, tune: in_tune_value};
    rd_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; t_nxt = t_r; f_nxt = f_r; tune_nxt = tune_r;
    st_nxt = st_r; k_nxt = k_r; single_nxt = single_r;
    eerr_nxt = eerr_r; ehalf_nxt = ehalf_r; eq_nxt = eq_r;
    gfound_nxt = gfound_r; gerr_nxt = gerr_r; ghalf_nxt = ghalf_r; gq_nxt = gq_r;
    gidx_nxt = gidx_r; gtune_nxt = gtune_r;
    valid_nxt = valid_r;
    ov_nxt = 1'b0; os_nxt = 1'b1; oi_nxt = '0; ot_nxt = '0; oh_nxt = '0;
    oa_nxt = '0; ok_nxt = '0;
    div_go = 1'b0; div_num = DW'(f_r); div_den = {cand[DW-2:0], 1'b0};
    case (state_r)
      osc_sel_pkg::S_IDLE: begin
        if (accept) begin
          ov_nxt = 1'b1;
          case (in_kind)
            osc_sel_pkg::KIND_STORE: begin
              if (in_ok) begin
                os_nxt = 1'b0;
                valid_nxt[in_entry_index] = 1'b1;
              end
            end
            osc_sel_pkg::KIND_CLEAR: begin
              os_nxt = 1'b0;
              valid_nxt = '0;
            end
            osc_sel_pkg::KIND_SELECT: begin
              if (in_target_hz != 32'd0) begin
                ov_nxt = 1'b0;
                t_nxt = in_target_hz;
                idx_nxt = '0;
                gfound_nxt = 1'b0;
                state_nxt = osc_sel_pkg::S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      osc_sel_pkg::S_READ: state_nxt = osc_sel_pkg::S_CHECK;
      osc_sel_pkg::S_CHECK: begin
        if (rd_ok) begin
          f_nxt = rd_r.hz;
          tune_nxt = rd_r.tune;
          eerr_nxt = DW'(32'hFFFF_FFFF);
          if (t_r >= rd_r.hz) begin
            st_nxt = DW'(1); k_nxt = 3'd3; single_nxt = 1'b1;
            state_nxt = osc_sel_pkg::S_CAND;
          end else begin
            div_go = 1'b1;
            div_num = DW'(rd_r.hz) + DW'(t_r);
            div_den = {DW'(t_r)} << 1;
            state_nxt = osc_sel_pkg::S_START;
          end
        end else begin
          state_nxt = osc_sel_pkg::S_NEXT;
        end
      end
      osc_sel_pkg::S_START: begin
        if (div_done) begin
          st_nxt = (div_q == '0) ? DW'(1) : ((div_q > HMAX) ? HMAX : div_q);
          k_nxt = '0; single_nxt = 1'b0;
          state_nxt = osc_sel_pkg::S_CAND;
        end
      end
      osc_sel_pkg::S_CAND: begin
        if (plus >= DW'(4) && cand <= HMAX) begin
          div_go = 1'b1;
          state_nxt = osc_sel_pkg::S_CWAIT;
        end else if (single_r || k_r == 3'd6) begin
          state_nxt = osc_sel_pkg::S_EDONE;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      osc_sel_pkg::S_CWAIT: begin
        if (div_done) begin
          if (err < eerr_r) begin
            eerr_nxt = err; ehalf_nxt = cand; eq_nxt = div_q;
          end
          if (single_r || k_r == 3'd6) begin
            state_nxt = osc_sel_pkg::S_EDONE;
          end else begin
            k_nxt = k_r + 3'd1;
            state_nxt = osc_sel_pkg::S_CAND;
          end
        end
      end
      osc_sel_pkg::S_EDONE: begin
        if (!gfound_r || eerr_r < gerr_r) begin
          gfound_nxt = 1'b1; gerr_nxt = eerr_r; ghalf_nxt = ehalf_r; gq_nxt = eq_r;
          gidx_nxt = idx_r; gtune_nxt = tune_r;
        end
        state_nxt = osc_sel_pkg::S_NEXT;
      end
      osc_sel_pkg::S_NEXT: begin
        if (idx_r == LAST) begin
          if (gfound_r) begin
            state_nxt = osc_sel_pkg::S_KWAIT;
          end else begin
            ov_nxt = 1'b1;
            state_nxt = osc_sel_pkg::S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 4'd1;
          state_nxt = osc_sel_pkg::S_READ;
        end
      end
      osc_sel_pkg::S_KWAIT: begin
        ov_nxt = 1'b1; os_nxt = 1'b0;
        oi_nxt = gidx_r; ot_nxt = gtune_r; oh_nxt = ghalf_r[15:0];
        oa_nxt = gq_r[27:0]; ok_nxt = kprod_r[59:37];
        state_nxt = osc_sel_pkg::S_IDLE;
      end
      default: state_nxt = osc_sel_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osc_sel_pkg::S_IDLE;
      valid_r <= '0;
      ov_r <= 1'b0;
      gfound_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      ov_r <= ov_nxt;
      gfound_r <= gfound_nxt;
    end
    idx_r <= idx_nxt; t_r <= t_nxt; f_r <= f_nxt; tune_r <= tune_nxt;
    st_r <= st_nxt; k_r <= k_nxt; single_r <= single_nxt;
    eerr_r <= eerr_nxt; ehalf_r <= ehalf_nxt; eq_r <= eq_nxt;
    gerr_r <= gerr_nxt; ghalf_r <= ghalf_nxt; gq_r <= gq_nxt;
    gidx_r <= gidx_nxt; gtune_r <= gtune_nxt;
    os_r <= os_nxt; oi_r <= oi_nxt; ot_r <= ot_nxt; oh_r <= oh_nxt;
    oa_r <= oa_nxt; ok_r <= ok_nxt;
    kprod_r <= kprod_nxt;
  end

  assign busy             = (state_r != osc_sel_pkg::S_IDLE);
  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_chosen_index = oi_r;
  assign out_chosen_tune  = ot_r;
  assign out_half_edges   = oh_r;
  assign out_achieved_hz  = oa_r;
  assign out_target_khz   = ok_r;

  a_div_in_scan: assert property (@(posedge clk) disable iff (!rst_n) div_busy |-> busy)
    else $error("divider running while idle");
  a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
      (accept && in_kind == osc_sel_pkg::KIND_SELECT && in_target_hz != 32'd0) |=> busy)
    else $error("select did not start scan");
  a_found_idx: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == osc_sel_pkg::S_KWAIT) |-> (gfound_r && 32'(gidx_r) < 32'(ENTRIES)))
    else $error("bad chosen entry");
  a_ok_half: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == osc_sel_pkg::S_CWAIT) |-> (cand != '0 && cand <= HMAX))
    else $error("candidate divider out of range");
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the oscillator setting selector: store, clear, select and no-op items with a scoreboard.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned N_ENTRIES = 16;
  localparam int unsigned N_HALF_MAX = 65535;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic        status;
    logic [3:0]  index;
    logic [11:0] tune;
    logic [15:0] half;
    logic [27:0] hz;
    logic [22:0] khz;
  } setting_t;

  class setting_scoreboard;
    logic [31:0] bank_hz [N_ENTRIES];
    logic [11:0] bank_tune [N_ENTRIES];
    bit          bank_ok [N_ENTRIES];
    setting_t    pending[$];
    int          errors;
    int          checked;

    function void wipe();
      for (int i = 0; i < N_ENTRIES; i++) begin
        bank_hz[i] = '0;
        bank_tune[i] = '0;
        bank_ok[i] = 0;
      end
    endfunction

    function bit fits_band(int unsigned b, logic [31:0] hz);
      if (b >= N_ENTRIES || hz == 0) return 0;
      return hz >= osc_sel_pkg::BAND_LO[b] && hz <= osc_sel_pkg::BAND_HI[b];
    endfunction

    function longint unsigned abs_diff(longint unsigned a, longint unsigned b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function longint unsigned best_divider(longint unsigned fb, longint unsigned tg);
      longint unsigned s, best, berr, err;
      longint c;
      if (tg >= fb) return 1;
      s = (fb + tg) / (tg * 2);
      if (s < 1) s = 1;
      if (s > N_HALF_MAX) s = N_HALF_MAX;
      best = s;
      berr = 64'hFFFF_FFFF;
      for (int d = -3; d <= 3; d++) begin
        c = longint'(s) + d;
        if (c < 1 || c > N_HALF_MAX) continue;
        err = abs_diff(fb / (2 * c), tg);
        if (err < berr) begin
          berr = err;
          best = c;
        end
      end
      return best;
    endfunction

    function void note_item(osc_sel_pkg::kind_t k, logic [3:0] idx, logic [11:0] tv,
                            logic [31:0] ehz, logic [31:0] thz);
      setting_t r;
      bit found;
      longint unsigned h, f, e, be;
      r = '{1'b1, '0, '0, '0, '0, '0};
      found = 0;
      be = 0;
      case (k)
        osc_sel_pkg::KIND_STORE: begin
          if (fits_band(idx, ehz)) begin
            bank_hz[idx] = ehz;
            bank_tune[idx] = tv;
            bank_ok[idx] = 1;
            r.status = 0;
          end
        end
        osc_sel_pkg::KIND_CLEAR: begin
          wipe();
          r.status = 0;
        end
        osc_sel_pkg::KIND_SELECT: begin
          if (thz != 0) begin
            for (int i = 0; i < N_ENTRIES; i++) begin
              if (!bank_ok[i] || !fits_band(i, bank_hz[i])) continue;
              h = best_divider(bank_hz[i], thz);
              f = longint'(bank_hz[i]) / (2 * h);
              e = abs_diff(f, thz);
              if (!found || e < be) begin
                found = 1;
                be = e;
                r.index = i;
                r.tune = bank_tune[i];
                r.half = h[15:0];
                r.hz = f[27:0];
              end
            end
            if (found) begin
              r.status = 0;
              r.khz = 23'((longint'(thz) + 999) / 1000);
            end else begin
              r = '{1'b1, '0, '0, '0, '0, '0};
            end
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(setting_t got);
      setting_t x;
      if (pending.size() == 0) begin
        $display("%0t unexpected result status=%0d", $time, got.status);
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      if (got.status !== x.status) begin
        $display("%0t status exp %0d got %0d", $time, x.status, got.status); errors++;
      end
      if (got.index !== x.index) begin
        $display("%0t index exp %0d got %0d", $time, x.index, got.index); errors++;
      end
      if (got.tune !== x.tune) begin
        $display("%0t tune exp %0d got %0d", $time, x.tune, got.tune); errors++;
      end
      if (got.half !== x.half) begin
        $display("%0t half exp %0d got %0d", $time, x.half, got.half); errors++;
      end
      if (got.hz !== x.hz) begin
        $display("%0t hz exp %0d got %0d", $time, x.hz, got.hz); errors++;
      end
      if (got.khz !== x.khz) begin
        $display("%0t khz exp %0d got %0d", $time, x.khz, got.khz); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0;
  logic [1:0] in_kind = '0;
  logic [3:0] in_entry_index = '0;
  logic [11:0] in_tune_value = '0;
  logic [31:0] in_entry_hz = '0, in_target_hz = '0;
  logic busy, out_valid, out_status;
  logic [3:0] out_chosen_index;
  logic [11:0] out_chosen_tune;
  logic [15:0] out_half_edges;
  logic [27:0] out_achieved_hz;
  logic [22:0] out_target_khz;

  setting_scoreboard sb;
  int idle_pct;
  int stall_count;
  int n_sel, n_store;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  oscillator_setting_selector_unit dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_status, out_chosen_index, out_chosen_tune, out_half_edges,
                        out_achieved_hz, out_target_khz});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count > WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(osc_sel_pkg::kind_t k, logic [3:0] idx, logic [11:0] tv,
                           logic [31:0] ehz, logic [31:0] thz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_kind <= k;
    in_entry_index <= idx;
    in_tune_value <= tv;
    in_entry_hz <= ehz;
    in_target_hz <= thz;
    do @(posedge clk); while (busy);
    sb.note_item(k, idx, tv, ehz, thz);
    if (k == osc_sel_pkg::KIND_SELECT) n_sel++;
    if (k == osc_sel_pkg::KIND_STORE) n_store++;
  endtask

  function automatic logic [31:0] band_hz(int b);
    case ($urandom_range(5))
      0: return osc_sel_pkg::BAND_LO[b];
      1: return osc_sel_pkg::BAND_HI[b];
      2: return osc_sel_pkg::BAND_LO[b] - 1;
      3: return osc_sel_pkg::BAND_HI[b] + 1;
      default: return $urandom_range(osc_sel_pkg::BAND_HI[b], osc_sel_pkg::BAND_LO[b]);
    endcase
  endfunction

  function automatic logic [31:0] rand_target();
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(3);
      2: return $urandom_range(2000);
      3: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(200000000, 1000);
    endcase
  endfunction

  task automatic random_item();
    int r, b;
    r = $urandom_range(99);
    b = $urandom_range(15);
    if (r < 50) send_item(osc_sel_pkg::KIND_STORE, b, $urandom, band_hz(b), $urandom);
    else if (r < 55) send_item(osc_sel_pkg::KIND_STORE, b, $urandom, $urandom, $urandom);
    else if (r < 92)
      send_item(osc_sel_pkg::KIND_SELECT, $urandom, $urandom, $urandom, rand_target());
    else if (r < 96)
      send_item(osc_sel_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
    else send_item(osc_sel_pkg::KIND_NONE, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    sb = new();
    sb.wipe();
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_item(osc_sel_pkg::KIND_SELECT, 0, 0, 0, 32'd1000);
    send_item(osc_sel_pkg::KIND_SELECT, 0, 0, 0, 32'd0);
    send_item(osc_sel_pkg::KIND_STORE, 0, 12'hFFF, 32'd0, 0);
    send_item(osc_sel_pkg::KIND_STORE, 0, 12'hFFF, osc_sel_pkg::BAND_HI[0], 0);
    send_item(osc_sel_pkg::KIND_STORE, 15, 12'h000, osc_sel_pkg::BAND_LO[15], 0);
    send_item(osc_sel_pkg::KIND_STORE, 3, 12'hA5A, 32'hFFFF_FFFF, 0);
    send_item(osc_sel_pkg::KIND_STORE, 7, 12'h123, osc_sel_pkg::BAND_LO[7] - 1, 0);
    send_item(osc_sel_pkg::KIND_STORE, 7, 12'h5A5, 32'd20000000, 0);
    send_item(osc_sel_pkg::KIND_SELECT, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(osc_sel_pkg::KIND_SELECT, 0, 0, 0, 32'd1);
    send_item(osc_sel_pkg::KIND_SELECT, 0, 0, 0, 32'd10000000);
    send_item(osc_sel_pkg::KIND_SELECT, 0, 0, 0, 32'd2);
    send_item(osc_sel_pkg::KIND_STORE, 8, 12'h5A5, 32'd20000000, 0);
    send_item(osc_sel_pkg::KIND_SELECT, 0, 0, 0, 32'd1000001);
    send_item(osc_sel_pkg::KIND_NONE, 4'hF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(osc_sel_pkg::KIND_CLEAR, 0, 0, 0, 0);
    send_item(osc_sel_pkg::KIND_SELECT, 0, 0, 0, 32'd5000);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 18 : (ph == 1) ? 58 : 0;
      for (int i = 0; i < 250; i++) random_item();
    end
    drain();
    $display("tb: %0d results checked, %0d selects, %0d stores", sb.checked, n_sel, n_store);
    $display("tb: idle phases 18%%, 58%% and none covered");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
